[sv/ltc_pkg.sv]
// ltc_pkg: shared types, class codes and the fixed word table of the token classifier.
// No dependencies; used by every file under sv/.
package ltc_pkg;

  localparam int NUM_WORDS  = 24;
  localparam int WORD_CHARS = 8;
  localparam logic [3:0] POS_SAT = 4'd8;

  typedef logic [3:0] tok_class_t;

  localparam tok_class_t CLS_ARITH      = 4'd0;
  localparam tok_class_t CLS_ASSIGN     = 4'd1;
  localparam tok_class_t CLS_RELATIONAL = 4'd2;
  localparam tok_class_t CLS_LOGICAL    = 4'd3;
  localparam tok_class_t CLS_KEYWORD    = 4'd4;
  localparam tok_class_t CLS_RESERVED   = 4'd5;
  localparam tok_class_t CLS_RES_BOOL   = 4'd6;
  localparam tok_class_t CLS_NOISE      = 4'd7;
  localparam tok_class_t CLS_LINE_CMT   = 4'd8;
  localparam tok_class_t CLS_BLOCK_CMT  = 4'd9;
  localparam tok_class_t CLS_DELIMITER  = 4'd10;
  localparam tok_class_t CLS_IDENT      = 4'd11;
  localparam tok_class_t CLS_REAL       = 4'd12;
  localparam tok_class_t CLS_INTEGER    = 4'd13;
  localparam tok_class_t CLS_INVALID    = 4'd14;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_POINT      = 8'h2E;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_EQ         = 8'h3D;
  localparam logic [7:0] CH_BANG       = 8'h21;
  localparam logic [7:0] CH_AMP        = 8'h26;
  localparam logic [7:0] CH_BAR        = 8'h7C;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_PCT        = 8'h25;
  localparam logic [7:0] CH_GT         = 8'h3E;
  localparam logic [7:0] CH_LT         = 8'h3C;

  // Word text, padded with zero bytes; the length table guards the padding.
  localparam logic [7:0] WORD_TEXT [NUM_WORDS][WORD_CHARS] = '{
    '{"b","o","o","l",8'h0,8'h0,8'h0,8'h0},
    '{"c","h","a","r",8'h0,8'h0,8'h0,8'h0},
    '{"d","e","f","a","u","l","t",8'h0},
    '{"d","o","u","b","l","e",8'h0,8'h0},
    '{"d","r","o","p",8'h0,8'h0,8'h0,8'h0},
    '{"e","l","s","e",8'h0,8'h0,8'h0,8'h0},
    '{"f","l","o","a","t",8'h0,8'h0,8'h0},
    '{"h","i","g","h",8'h0,8'h0,8'h0,8'h0},
    '{"i","f",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
    '{"i","n","p",8'h0,8'h0,8'h0,8'h0,8'h0},
    '{"i","n","t",8'h0,8'h0,8'h0,8'h0,8'h0},
    '{"l","o","w",8'h0,8'h0,8'h0,8'h0,8'h0},
    '{"o","u","t",8'h0,8'h0,8'h0,8'h0,8'h0},
    '{"p","o","w",8'h0,8'h0,8'h0,8'h0,8'h0},
    '{"t","e","r","m",8'h0,8'h0,8'h0,8'h0},
    '{"u","n","t","i","l",8'h0,8'h0,8'h0},
    '{"b","o","d","y",8'h0,8'h0,8'h0,8'h0},
    '{"n","e","x","t",8'h0,8'h0,8'h0,8'h0},
    '{"i","n","V","a","l","i","d",8'h0},
    '{"v","a","l","i","d",8'h0,8'h0,8'h0},
    '{"i","n","p","u","t",8'h0,8'h0,8'h0},
    '{"i","n","t","e","g","e","r",8'h0},
    '{"o","u","t","p","u","t",8'h0,8'h0},
    '{"p","o","w","e","r",8'h0,8'h0,8'h0}
  };

  localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
    4'd4, 4'd4, 4'd7, 4'd6, 4'd4, 4'd4, 4'd5, 4'd4,
    4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd5,
    4'd4, 4'd4, 4'd7, 4'd5, 4'd5, 4'd7, 4'd6, 4'd5
  };

  localparam tok_class_t WORD_CLASS [NUM_WORDS] = '{
    CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
    CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
    CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
    CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
    CLS_RESERVED, CLS_RESERVED, CLS_RES_BOOL, CLS_RES_BOOL,
    CLS_NOISE, CLS_NOISE, CLS_NOISE, CLS_NOISE
  };

  // Token summary as seen after the current character is folded in.
  typedef struct packed {
    logic [7:0]           first;
    logic [7:0]           second;
    logic [3:0]           len;
    logic [NUM_WORDS-1:0] cand;
    logic                 all_num;
    logic                 has_pt;
  } tok_view_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
           (c == CH_UNDERSCORE);
  endfunction

endpackage

[sv/ltc_if.sv]
// ltc_in_if / ltc_out_if: valid-ready channels of the token classifier.
// Depends on ltc_pkg for the class type.
interface ltc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface ltc_out_if;
  logic                valid;
  logic                ready;
  ltc_pkg::tok_class_t token_class;

  modport source (output valid, output token_class, input ready);
  modport sink   (input valid, input token_class, output ready);
endinterface

[sv/lexical_token_classifier.sv]
// lexical_token_classifier: top level, one character per transaction in, one class out.
// Depends on ltc_pkg, ltc_if, ltc_tracker and ltc_classifier.
//
// Usage:
//   in_ch carries one character of a token per transaction; last_char marks the
//   token's final character. Only that final transaction yields a result.
//   out_ch carries token_class for each finished token, in token order.
//   Output: the class is registered and appears on out_ch in the cycle after the
//   final character is accepted.
//   Throughput: one character per cycle, sustained while no final character waits;
//   the per-character work is a 24-way byte compare against the word table plus
//   the class decode, all between the tracker state and the output register.
//   Stall: while an undelivered result sits in the output register and the
//   receiver holds ready low, characters that are not final are still taken;
//   a final character waits until the output register frees up.
//   Reset (rst_n low, synchronous): token state returns to empty and the
//   output register is emptied.
module lexical_token_classifier (
  input  logic     clk,
  input  logic     rst_n,
  ltc_in_if.sink   in_ch,
  ltc_out_if.source out_ch
);

  logic                in_acc;
  logic                out_valid_r, out_valid_nxt;
  ltc_pkg::tok_class_t class_r;
  ltc_pkg::tok_class_t class_c;
  ltc_pkg::tok_view_t  view;

  assign in_ch.ready = !out_valid_r || out_ch.ready || !in_ch.last_char;
  assign in_acc      = in_ch.valid && in_ch.ready;

  ltc_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .char_in   (in_ch.char_in),
    .last_char (in_ch.last_char),
    .view      (view)
  );

  ltc_classifier u_classifier (
    .view        (view),
    .token_class (class_c)
  );

  always_comb begin
    if (in_acc && in_ch.last_char)
      out_valid_nxt = 1'b1;
    else if (out_ch.ready)
      out_valid_nxt = 1'b0;
    else
      out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else
      out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.last_char)
      class_r <= class_c;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.token_class = class_r;

endmodule

[sv/ltc_tracker.sv]
// ltc_tracker: per-token state (position, first two chars, word candidates, numeric flags).
// Depends on ltc_pkg. Presents the state with the current character folded in.
module ltc_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          char_in,
  input  logic                last_char,
  output ltc_pkg::tok_view_t  view
);

  logic [3:0]                    pos_r, pos_nxt;
  logic [7:0]                    first_r, first_nxt;
  logic [7:0]                    second_r, second_nxt;
  logic [ltc_pkg::NUM_WORDS-1:0] cand_r, cand_nxt;
  logic                          all_num_r, all_num_nxt;
  logic                          has_pt_r, has_pt_nxt;
  logic [ltc_pkg::NUM_WORDS-1:0] hit;
  logic                          is_pt;

  always_comb begin
    for (int i = 0; i < ltc_pkg::NUM_WORDS; i++) begin
      hit[i] = (pos_r < ltc_pkg::WORD_LEN[i]) &&
               (ltc_pkg::WORD_TEXT[i][pos_r[2:0]] == char_in);
    end
  end

  assign is_pt = (char_in == ltc_pkg::CH_POINT);

  always_comb begin
    first_nxt  = (pos_r == 4'd0) ? char_in : first_r;
    second_nxt = (pos_r == 4'd1) ? char_in : second_r;
    if (pos_r < ltc_pkg::POS_SAT) begin
      cand_nxt = cand_r & hit;
      pos_nxt  = pos_r + 4'd1;
    end else begin
      cand_nxt = '0;
      pos_nxt  = pos_r;
    end
    all_num_nxt = all_num_r & (ltc_pkg::is_digit(char_in) | is_pt);
    has_pt_nxt  = has_pt_r | is_pt;
  end

  always_comb begin
    view.first   = first_nxt;
    view.second  = second_nxt;
    view.len     = pos_nxt;
    view.cand    = cand_nxt;
    view.all_num = all_num_nxt;
    view.has_pt  = has_pt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_char)) begin
      pos_r     <= '0;
      first_r   <= '0;
      second_r  <= '0;
      cand_r    <= '1;
      all_num_r <= 1'b1;
      has_pt_r  <= 1'b0;
    end else if (accept) begin
      pos_r     <= pos_nxt;
      first_r   <= first_nxt;
      second_r  <= second_nxt;
      cand_r    <= cand_nxt;
      all_num_r <= all_num_nxt;
      has_pt_r  <= has_pt_nxt;
    end
  end

endmodule

[sv/ltc_classifier.sv]
// ltc_classifier: maps a finished token summary to its class code.
// Depends on ltc_pkg. Purely combinational.
module ltc_classifier (
  input  ltc_pkg::tok_view_t  view,
  output ltc_pkg::tok_class_t token_class
);

  logic [7:0]          f, s;
  logic                two, pm_pct;
  logic                word_hit;
  ltc_pkg::tok_class_t word_cls;

  assign f      = view.first;
  assign s      = view.second;
  assign two    = (view.len == 4'd2);
  assign pm_pct = (f == ltc_pkg::CH_PLUS) || (f == ltc_pkg::CH_MINUS) ||
                  (f == ltc_pkg::CH_PCT);

  // At most one word can survive at a given length; lowest index wins anyway.
  always_comb begin
    word_hit = 1'b0;
    word_cls = ltc_pkg::CLS_IDENT;
    for (int i = ltc_pkg::NUM_WORDS - 1; i >= 0; i--) begin
      if (view.cand[i] && (ltc_pkg::WORD_LEN[i] == view.len)) begin
        word_hit = 1'b1;
        word_cls = ltc_pkg::WORD_CLASS[i];
      end
    end
  end

  always_comb begin
    if ((f == ltc_pkg::CH_SLASH) || (f == ltc_pkg::CH_STAR)) begin
      if (two && (f == ltc_pkg::CH_SLASH) && (s == ltc_pkg::CH_SLASH))
        token_class = ltc_pkg::CLS_LINE_CMT;
      else if (two && (((f == ltc_pkg::CH_SLASH) && (s == ltc_pkg::CH_STAR)) ||
                       ((f == ltc_pkg::CH_STAR) && (s == ltc_pkg::CH_SLASH))))
        token_class = ltc_pkg::CLS_BLOCK_CMT;
      else
        token_class = ltc_pkg::CLS_INVALID;
    end else if (f == ltc_pkg::CH_SEMI) begin
      token_class = (view.len == 4'd1) ? ltc_pkg::CLS_DELIMITER : ltc_pkg::CLS_INVALID;
    end else if (ltc_pkg::is_letter(f)) begin
      token_class = word_hit ? word_cls : ltc_pkg::CLS_IDENT;
    end else if (((f == ltc_pkg::CH_BANG) && (s == ltc_pkg::CH_EQ)) ||
                 ((f == ltc_pkg::CH_AMP) && (s == ltc_pkg::CH_AMP)) ||
                 ((f == ltc_pkg::CH_BAR) && (s == ltc_pkg::CH_BAR))) begin
      token_class = ltc_pkg::CLS_LOGICAL;
    end else if (((f == ltc_pkg::CH_EQ) && (s == ltc_pkg::CH_EQ)) ||
                 (f == ltc_pkg::CH_GT) || (f == ltc_pkg::CH_LT)) begin
      token_class = ltc_pkg::CLS_RELATIONAL;
    end else if ((f == ltc_pkg::CH_EQ) || (pm_pct && (s == ltc_pkg::CH_EQ))) begin
      token_class = ltc_pkg::CLS_ASSIGN;
    end else if (pm_pct) begin
      token_class = ltc_pkg::CLS_ARITH;
    end else if ((ltc_pkg::is_digit(f) || (f == ltc_pkg::CH_POINT)) && view.all_num) begin
      token_class = view.has_pt ? ltc_pkg::CLS_REAL : ltc_pkg::CLS_INTEGER;
    end else begin
      token_class = ltc_pkg::CLS_INVALID;
    end
  end

endmodule

[sv/ltc_checker.sv]
// ltc_checker: port-level assertions for lexical_token_classifier, bound to the top level.
// Depends on ltc_pkg for the class codes.
module ltc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_last,
  input logic                out_valid,
  input logic                out_ready,
  input ltc_pkg::tok_class_t out_class
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A final character always produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> out_valid)
    else $error("final character accepted without a result");

  // A fresh result only appears right after a final character was taken.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid && !out_ready) |-> $past(in_acc && in_last))
    else $error("result without a final character");

  // An empty output side never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output register");

  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_class <= ltc_pkg::CLS_INVALID))
    else $error("class code out of range");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_class))
    else $error("stalled result changed or dropped");

endmodule

bind lexical_token_classifier ltc_checker u_ltc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_char),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_class (out_ch.token_class)
);

[sim/lexical_token_classifier_tb.sv]
// lexical_token_classifier_tb: self-checking bench for the token classifier.
// Depends on ltc_pkg, ltc_if and lexical_token_classifier; drives characters in,
// predicts each token's class and checks every result transaction in order.
module lexical_token_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ltc_pkg::*;

  logic clk;
  logic rst_n;

  ltc_in_if  in_ch ();
  ltc_out_if out_ch ();

  lexical_token_classifier DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Scanner state of the token in flight, as the predictor sees it.
  typedef struct packed {
    logic [3:0]  n_seen;
    logic [7:0]  lead;
    logic [7:0]  follow;
    logic [23:0] live_words;
    logic        numeric;
    logic        dotted;
  } scan_state_t;

  localparam scan_state_t SCAN_EMPTY = '{4'd0, 8'd0, 8'd0, 24'hFFFFFF, 1'b1, 1'b0};

  string kw_text [24] = '{
    "bool", "char", "default", "double", "drop", "else", "float", "high",
    "if", "inp", "int", "low", "out", "pow", "term", "until",
    "body", "next", "inValid", "valid", "input", "integer", "output", "power"
  };

  tok_class_t kw_kind [24] = '{
    CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
    CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
    CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
    CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
    CLS_RESERVED, CLS_RESERVED, CLS_RES_BOOL, CLS_RES_BOOL,
    CLS_NOISE, CLS_NOISE, CLS_NOISE, CLS_NOISE
  };

  logic [7:0] op_lead [9] = '{CH_PLUS, CH_MINUS, CH_PCT, CH_EQ, CH_BANG,
                              CH_AMP, CH_BAR, CH_GT, CH_LT};

  string name_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

  scan_state_t scan = SCAN_EMPTY;
  tok_class_t  pending_classes [$];
  int          mismatches = 0;
  int          chars_sent = 0;
  int          rx_hold_req = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
  endfunction

  function automatic tok_class_t judge_token(scan_state_t s);
    logic [7:0] f;
    logic [7:0] g;
    int         len;
    f   = s.lead;
    g   = s.follow;
    len = s.n_seen;
    if (f == CH_SLASH || f == CH_STAR) begin
      if (len == 2 && f == CH_SLASH && g == CH_SLASH) return CLS_LINE_CMT;
      if (len == 2 && ((f == CH_SLASH && g == CH_STAR) || (f == CH_STAR && g == CH_SLASH)))
        return CLS_BLOCK_CMT;
      return CLS_INVALID;
    end
    if (f == CH_SEMI) return (len == 1) ? CLS_DELIMITER : CLS_INVALID;
    if (alpha_ch(f)) begin
      for (int i = 0; i < 24; i++)
        if (s.live_words[i] && kw_text[i].len() == len) return kw_kind[i];
      return CLS_IDENT;
    end
    if ((f == CH_BANG && g == CH_EQ) || (f == CH_AMP && g == CH_AMP) ||
        (f == CH_BAR && g == CH_BAR))
      return CLS_LOGICAL;
    if ((f == CH_EQ && g == CH_EQ) || f == CH_GT || f == CH_LT) return CLS_RELATIONAL;
    if (f == CH_EQ || ((f == CH_PLUS || f == CH_MINUS || f == CH_PCT) && g == CH_EQ))
      return CLS_ASSIGN;
    if (f == CH_PLUS || f == CH_MINUS || f == CH_PCT) return CLS_ARITH;
    if ((digit_ch(f) || f == CH_POINT) && s.numeric)
      return s.dotted ? CLS_REAL : CLS_INTEGER;
    return CLS_INVALID;
  endfunction

  // Folds one accepted character into the scan; a final character yields a class.
  function automatic void fold_char(input logic [7:0] c, input logic fin,
                                    output bit emit, output tok_class_t cls);
    int p;
    p = scan.n_seen;
    if (p == 0) scan.lead = c;
    if (p == 1) scan.follow = c;
    if (p < 8) begin
      for (int i = 0; i < 24; i++)
        if (p >= kw_text[i].len() || kw_text[i][p] != c) scan.live_words[i] = 1'b0;
      scan.n_seen = p + 1;
    end else begin
      scan.live_words = '0;
    end
    if (!digit_ch(c) && c != CH_POINT) scan.numeric = 1'b0;
    if (c == CH_POINT) scan.dotted = 1'b1;
    emit = fin;
    cls  = CLS_INVALID;
    if (fin) begin
      cls  = judge_token(scan);
      scan = SCAN_EMPTY;
    end
  endfunction

  function automatic void log_fault(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // ------------------------------------------------------------ check process
  always @(posedge clk) begin
    bit         emit;
    tok_class_t cls;
    tok_class_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        fold_char(in_ch.char_in, in_ch.last_char, emit, cls);
        if (emit) pending_classes.push_back(cls);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_classes.size() == 0) begin
          log_fault($sformatf("unexpected result: token_class %0d", out_ch.token_class));
        end else begin
          want = pending_classes.pop_front();
          if (out_ch.token_class !== want)
            log_fault($sformatf("token_class mismatch: expected %0d, got %0d",
                                want, out_ch.token_class));
        end
      end
    end
  end

  // ------------------------------------------------------------- idle timing
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req != 0) begin
        n = rx_hold_req;
        rx_hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (1 + gap_len()) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ------------------------------------------------------------------ driving
  task automatic put_char(input logic [7:0] c, input logic fin);
    int g;
    in_ch.valid     <= 1'b1;
    in_ch.char_in   <= c;
    in_ch.last_char <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    chars_sent++;
    g = tx_gaps_on ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid     <= 1'b0;
      in_ch.char_in   <= 8'($urandom);
      in_ch.last_char <= 1'($urandom);
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_token(input logic [7:0] t[$]);
    foreach (t[i]) put_char(t[i], i == t.size() - 1);
  endtask

  task automatic send_word(input string s);
    logic [7:0] t[$];
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    send_token(t);
  endtask

  // Sender pause: stop offering and let every expected class come out.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_classes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_name_char(int hi);
    return name_chars[$urandom_range(0, hi)];
  endfunction

  function automatic logic [7:0] pick_printable();
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic int pick_len();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
  endfunction

  // Mostly well-formed tokens with random content, some broken ones, some noise.
  task automatic make_token(output logic [7:0] t[$]);
    int    kind;
    int    n;
    int    r;
    string s;
    t = {};
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      s = kw_text[$urandom_range(0, 23)];
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      case ($urandom_range(0, 9))
        0, 1, 2: t.push_back(pick_name_char(62));
        3:       void'(t.pop_back());
        4: begin
          n = $urandom_range(0, t.size() - 1);
          t[n] = t[n] ^ 8'h20;
        end
        default: ;
      endcase
    end else if (kind < 45) begin
      t.push_back(op_lead[$urandom_range(0, 8)]);
      repeat ($urandom_range(0, 2))
        t.push_back(($urandom_range(0, 3) == 0) ? pick_printable() : op_lead[$urandom_range(0, 8)]);
    end else if (kind < 53) begin
      t.push_back($urandom_range(0, 1) ? CH_SLASH : CH_STAR);
      repeat ($urandom_range(0, 2)) begin
        r = $urandom_range(0, 3);
        t.push_back(r == 0 ? CH_SLASH : r == 1 ? CH_STAR : r == 2 ? CH_EQ : pick_printable());
      end
    end else if (kind < 58) begin
      t.push_back(CH_SEMI);
      if ($urandom_range(0, 2) == 0) t.push_back(pick_printable());
    end else if (kind < 73) begin
      t.push_back(pick_name_char(52));
      repeat (pick_len() - 1) t.push_back(pick_name_char(62));
    end else if (kind < 88) begin
      n = pick_len();
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 15) t.push_back(CH_POINT);
        else if (r < 95 || i == 0) t.push_back(8'("0" + $urandom_range(0, 9)));
        else t.push_back(pick_printable());
      end
    end else begin
      repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // -------------------------------------------------------------------- tests
  task automatic test_operators();
    send_word("+");
    send_word("%=");
    send_word("=");
    send_word("==");
    send_word("!=");
    send_word("&&");
    send_word("||");
    send_word("<x");
    send_word("&");
    send_word("!");
    wait_idle();
  endtask

  task automatic test_comments_and_delimiters();
    send_word("//");
    send_word("/*");
    send_word("*/");
    send_word("/=");
    send_word(";");
    send_word(";;");
    wait_idle();
  endtask

  task automatic test_words();
    send_word("inValid");
    send_word("body");
    send_word("integer");
    send_word("if");
    send_word("int_");
    send_word("outputvalue");
    wait_idle();
  endtask

  task automatic test_numbers();
    send_word("0");
    send_word("9.5");
    send_word(".");
    send_word("1..2");
    send_word("12a");
    send_word("123456789.01");
    wait_idle();
  endtask

  // Zero and high-bit characters as first characters, and a zero after a digit.
  task automatic test_odd_characters();
    send_token('{8'h00});
    send_token('{8'hFF, 8'h80});
    send_token('{"9", 8'h00});
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps offering back to back.
  task automatic test_backpressure();
    logic [7:0] t[$];
    tx_gaps_on  = 1'b0;
    rx_hold_req = 200;
    repeat (30) begin
      make_token(t);
      send_token(t);
    end
    wait_idle();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_stream();
    logic [7:0] t[$];
    int         stop_at;
    stop_at = chars_sent + 600;
    while (chars_sent < stop_at) begin
      // one stretch runs with no idling on either side
      tx_gaps_on = !(stop_at - chars_sent < 450 && stop_at - chars_sent > 300);
      rx_gaps_on = tx_gaps_on;
      make_token(t);
      send_token(t);
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    wait_idle();
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.char_in   <= 8'd0;
    in_ch.last_char <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_operators();
    test_comments_and_delimiters();
    test_words();
    test_numbers();
    test_odd_characters();
    test_backpressure();
    test_random_stream();

    repeat (10) @(posedge clk);
    if (pending_classes.size() != 0)
      log_fault($sformatf("%0d expected results never arrived", pending_classes.size()));
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
sv/ltc_pkg.sv
sv/ltc_if.sv
sv/ltc_tracker.sv
sv/ltc_classifier.sv
sv/lexical_token_classifier.sv
sv/ltc_checker.sv
sim/lexical_token_classifier_tb.sv
